/* src/ft12_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// FT1.2 frame builder package
// Beat types, frame byte constants and sizing defaults shared by the block.
// ---------------------------------------------------------------------------
package ft12_pkg;

  // Fixed frame bytes.
  localparam logic [7:0] StartByte = 8'h68;
  localparam logic [7:0] EndByte   = 8'h16;
  localparam logic [7:0] CtrlA     = 8'h73;
  localparam logic [7:0] CtrlB     = 8'h53;
  localparam logic [7:0] AckByte   = 8'hE5;

  // Sizing defaults.
  localparam int unsigned MaxPayloadDefault = 254;
  localparam int unsigned QueueDepthDefault = 2;

  // Input beat.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic [7:0] frame_length;
  } ft12_in_t;

  // Output beat.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       frame_done;
  } ft12_out_t;

  // Classified job handed from the front end to the byte sequencer.
  typedef struct packed {
    logic       has_header;
    logic [7:0] len_field;
    logic [7:0] ctrl_byte;
    logic [7:0] data_byte;
    logic       has_trailer;
    logic [7:0] checksum;
    logic       append_ack;
  } ft12_job_t;

endpackage

/* src/ft12_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// FT1.2 front end
// Accepts payload beats, tracks frame position and checksum, and turns each
// beat into one job for the byte sequencer.
// ---------------------------------------------------------------------------
module ft12_front #(
  parameter int unsigned MaxPayload = ft12_pkg::MaxPayloadDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ft12_pkg::ft12_in_t in_i,
  output logic               job_valid_o,
  input  logic               job_ready_i,
  output ft12_pkg::ft12_job_t job_o
);

  localparam int unsigned CntW = $clog2(MaxPayload + 1);

  logic            append_ack_q;
  logic            toggle_q;
  logic [CntW-1:0] remaining_q, remaining_d;
  logic [7:0]      sum_q, sum_d;

  logic            first;
  logic [7:0]      len_sat;
  logic [CntW-1:0] remaining_cur;
  logic            last;
  logic [7:0]      ctrl_byte;
  logic [7:0]      sum_new;
  logic            accept;

  // A frame starts whenever no payload bytes are outstanding.
  assign first = (remaining_q == '0);

  // Clamp the length into the legal range.
  always_comb begin
    len_sat = in_i.frame_length;
    if (in_i.frame_length == 8'd0) begin
      len_sat = 8'd1;
    end else if (in_i.frame_length > 8'(MaxPayload)) begin
      len_sat = 8'(MaxPayload);
    end
  end

  assign ctrl_byte     = toggle_q ? ft12_pkg::CtrlB : ft12_pkg::CtrlA;
  assign remaining_cur = first ? len_sat[CntW-1:0] : remaining_q;
  assign remaining_d   = remaining_cur - CntW'(1);
  assign last          = (remaining_d == '0);
  assign sum_new       = (first ? ctrl_byte : sum_q) + in_i.payload_byte;
  assign sum_d         = last ? 8'd0 : sum_new;

  // Job seen by the queue.
  assign in_ready_o  = job_ready_i;
  assign job_valid_o = in_valid_i;
  assign accept      = in_valid_i & job_ready_i;

  always_comb begin
    job_o.has_header  = first;
    job_o.len_field   = len_sat + 8'd1;
    job_o.ctrl_byte   = ctrl_byte;
    job_o.data_byte   = in_i.payload_byte;
    job_o.has_trailer = last;
    job_o.checksum    = sum_new;
    job_o.append_ack  = append_ack_q;
  end

  // Frame position, checksum and control toggle advance per accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      append_ack_q <= 1'b1;
      toggle_q     <= 1'b0;
      remaining_q  <= '0;
      sum_q        <= 8'd0;
    end else begin
      if (cfg_we_i) begin
        append_ack_q <= cfg_wdata_i;
      end
      if (accept) begin
        remaining_q <= remaining_d;
        sum_q       <= sum_d;
        toggle_q    <= toggle_q ^ last;
      end
    end
  end

endmodule

/* src/ft12_queue.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// FT1.2 job queue
// Short FIFO that decouples the front end from the byte sequencer.
// ---------------------------------------------------------------------------
module ft12_queue #(
  parameter int unsigned QueueDepth = ft12_pkg::QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  ft12_pkg::ft12_job_t push_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output ft12_pkg::ft12_job_t pop_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  ft12_pkg::ft12_job_t mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_o        = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

/* src/ft12_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// FT1.2 byte sequencer
// Expands each job into frame bytes, one per cycle unless stalled.
// ---------------------------------------------------------------------------
module ft12_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  output logic                job_ready_o,
  input  ft12_pkg::ft12_job_t job_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ft12_pkg::ft12_out_t out_o
);

  typedef enum logic [3:0] {
    StStart0,
    StLen0,
    StLen1,
    StStart1,
    StCtrl,
    StData,
    StSum,
    StEnd,
    StAck
  } step_e;

  step_e               step_q, step_cur, step_next;
  logic                in_job_q;
  logic                out_valid_q;
  ft12_pkg::ft12_out_t out_q;
  ft12_pkg::ft12_out_t beat;
  logic                job_last;
  logic                load;

  // A fresh job begins at the header or, mid-frame, at its data byte.
  always_comb begin
    if (in_job_q) begin
      step_cur = step_q;
    end else if (job_i.has_header) begin
      step_cur = StStart0;
    end else begin
      step_cur = StData;
    end
  end

  // Byte selection and end-of-job detection.
  always_comb begin
    beat.out_byte   = job_i.data_byte;
    beat.frame_done = 1'b0;
    job_last        = 1'b0;
    step_next       = StData;
    unique case (step_cur)
      StStart0: begin
        beat.out_byte = ft12_pkg::StartByte;
        step_next     = StLen0;
      end
      StLen0: begin
        beat.out_byte = job_i.len_field;
        step_next     = StLen1;
      end
      StLen1: begin
        beat.out_byte = job_i.len_field;
        step_next     = StStart1;
      end
      StStart1: begin
        beat.out_byte = ft12_pkg::StartByte;
        step_next     = StCtrl;
      end
      StCtrl: begin
        beat.out_byte = job_i.ctrl_byte;
        step_next     = StData;
      end
      StData: begin
        beat.out_byte = job_i.data_byte;
        job_last      = !job_i.has_trailer;
        step_next     = StSum;
      end
      StSum: begin
        beat.out_byte = job_i.checksum;
        step_next     = StEnd;
      end
      StEnd: begin
        beat.out_byte   = ft12_pkg::EndByte;
        beat.frame_done = !job_i.append_ack;
        job_last        = !job_i.append_ack;
        step_next       = StAck;
      end
      StAck: begin
        beat.out_byte   = ft12_pkg::AckByte;
        beat.frame_done = 1'b1;
        job_last        = 1'b1;
        step_next       = StData;
      end
      default: begin
        beat.out_byte   = job_i.data_byte;
        beat.frame_done = 1'b0;
        job_last        = 1'b0;
        step_next       = StData;
      end
    endcase
    beat.last_of_run = job_last;
  end

  // The output register takes a beat when empty or being drained.
  assign load        = job_valid_i & (!out_valid_q | out_ready_i);
  assign job_ready_o = load & job_last;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Sequencer state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= StStart0;
      in_job_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
        out_q       <= beat;
        in_job_q    <= !job_last;
        step_q      <= step_next;
      end
    end
  end

endmodule

/* src/ft12_frame_builder.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// FT1.2 variable-length frame builder
// Wraps a stream of payload bytes in FT1.2 frames with header and trailer.
// ---------------------------------------------------------------------------
// Each input beat carries one payload byte; the first beat of a frame also
// supplies the payload length. The front end accepts one beat per cycle while
// its job queue has room, and the byte sequencer emits exactly one output
// byte per cycle when the sink is ready. An input beat therefore yields its
// payload byte, after the header (start, length twice, start, control) when
// it opens a frame and before the trailer (checksum, end byte, optional 0xE5)
// when it closes one; the output byte rate bounds sustained throughput.
// The append_ack register resets to 1 and should be written only while no
// frame bytes are pending.
module ft12_frame_builder #(
  parameter int unsigned MaxPayload = ft12_pkg::MaxPayloadDefault,
  parameter int unsigned QueueDepth = ft12_pkg::QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ft12_pkg::ft12_in_t  in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ft12_pkg::ft12_out_t out_o
);

  logic                push_valid, push_ready;
  ft12_pkg::ft12_job_t push_job;
  logic                pop_valid, pop_ready;
  ft12_pkg::ft12_job_t pop_job;

  // Beat classification and frame bookkeeping.
  ft12_front #(
    .MaxPayload(MaxPayload)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .job_valid_o (push_valid),
    .job_ready_i (push_ready),
    .job_o       (push_job)
  );

  // Decoupling queue.
  ft12_queue #(
    .QueueDepth(QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_i       (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_o        (pop_job)
  );

  // Byte sequencer and output register.
  ft12_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .job_i       (pop_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

/* src/ft12_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// FT1.2 frame builder checker
// Port-level assertions on the input and output streams, bound to the top level.
// ---------------------------------------------------------------------------
module ft12_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input ft12_pkg::ft12_in_t  in_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ft12_pkg::ft12_out_t out_o
);

  // A stalled output beat holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("stalled output beat changed");

  // The closing byte of a frame also closes its input beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.frame_done |-> out_o.last_of_run)
    else $error("frame end without end of run");

  // A frame closes only on the end byte or the acknowledge byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.frame_done |->
      (out_o.out_byte == ft12_pkg::EndByte) || (out_o.out_byte == ft12_pkg::AckByte))
    else $error("frame closed on an unexpected byte");

  // A stalled input beat stays offered with the same payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_i))
    else $error("stalled input beat changed");

endmodule

bind ft12_frame_builder ft12_checker u_checker (.*);

/* tb/sv/ft12_frame_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// FT1.2 frame builder scoreboard
// Watches the input, output and register ports of the frame builder, works
// out the serial byte stream that each accepted input beat must produce and
// compares every accepted output beat against the oldest predicted byte.
// ---------------------------------------------------------------------------
module ft12_frame_checker #(
  parameter int unsigned MaxPayload = ft12_pkg::MaxPayloadDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  ft12_pkg::ft12_in_t  in_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  ft12_pkg::ft12_out_t out_i,
  output int                  error_count_o,
  output int                  pending_o
);

  // Bytes predicted but not yet seen on the output.
  ft12_pkg::ft12_out_t frame_bytes_q[$];

  // Shadow copy of the frame state and the ack register.
  logic       ctrl_toggle_q;
  logic [7:0] bytes_left_q;
  logic [7:0] frame_sum_q;
  logic       append_ack_q;

  int         error_count;
  int         beat_index;

  function automatic ft12_pkg::ft12_out_t frame_byte(input logic [7:0] value,
                                                     input logic done);
    ft12_pkg::ft12_out_t b;
    b.out_byte    = value;
    b.last_of_run = 1'b0;
    b.frame_done  = done;
    return b;
  endfunction

  // Appends the bytes one input beat produces: the header when it opens a
  // frame, the payload byte itself, and the trailer when it closes one.
  task automatic predict_frame_bytes(input ft12_pkg::ft12_in_t beat);
    logic [7:0]          len;
    logic [7:0]          ctrl;
    ft12_pkg::ft12_out_t tail;
    if (bytes_left_q == 8'd0) begin
      // A zero length still carries this beat's byte; oversize saturates.
      len = beat.frame_length;
      if (len == 8'd0) len = 8'd1;
      if (len > MaxPayload) len = MaxPayload[7:0];
      ctrl = ctrl_toggle_q ? ft12_pkg::CtrlB : ft12_pkg::CtrlA;
      frame_bytes_q.push_back(frame_byte(ft12_pkg::StartByte, 1'b0));
      frame_bytes_q.push_back(frame_byte(len + 8'd1, 1'b0));
      frame_bytes_q.push_back(frame_byte(len + 8'd1, 1'b0));
      frame_bytes_q.push_back(frame_byte(ft12_pkg::StartByte, 1'b0));
      frame_bytes_q.push_back(frame_byte(ctrl, 1'b0));
      frame_sum_q  = ctrl;
      bytes_left_q = len;
    end

    frame_bytes_q.push_back(frame_byte(beat.payload_byte, 1'b0));
    frame_sum_q  = frame_sum_q + beat.payload_byte;
    bytes_left_q = bytes_left_q - 8'd1;

    // The ack setting in force now decides whether 0xE5 closes the frame.
    if (bytes_left_q == 8'd0) begin
      frame_bytes_q.push_back(frame_byte(frame_sum_q, 1'b0));
      frame_bytes_q.push_back(frame_byte(ft12_pkg::EndByte, !append_ack_q));
      if (append_ack_q) frame_bytes_q.push_back(frame_byte(ft12_pkg::AckByte, 1'b1));
      ctrl_toggle_q = !ctrl_toggle_q;
      frame_sum_q   = 8'd0;
    end

    tail = frame_bytes_q.pop_back();
    tail.last_of_run = 1'b1;
    frame_bytes_q.push_back(tail);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    ft12_pkg::ft12_out_t want;
    if (!rst_ni) begin
      frame_bytes_q.delete();
      ctrl_toggle_q = 1'b0;
      bytes_left_q  = 8'd0;
      frame_sum_q   = 8'd0;
      append_ack_q  = 1'b1;
      error_count   = 0;
      beat_index    = 0;
      error_count_o <= 0;
      pending_o     <= 0;
    end else begin
      // Compare the output beat first: it can never belong to an input
      // beat accepted at this same edge.
      if (out_valid_i && out_ready_i) begin
        if (frame_bytes_q.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("ERROR: output beat %0d not expected: out_byte=%02h last=%0b done=%0b",
                     beat_index, out_i.out_byte, out_i.last_of_run, out_i.frame_done);
        end else begin
          want = frame_bytes_q.pop_front();
          if (want.out_byte !== out_i.out_byte || want.last_of_run !== out_i.last_of_run ||
              want.frame_done !== out_i.frame_done) begin
            error_count++;
            if (error_count <= 10)
              $display({"ERROR: output beat %0d: expected out_byte=%02h last=%0b done=%0b,",
                        " got out_byte=%02h last=%0b done=%0b"},
                       beat_index, want.out_byte, want.last_of_run, want.frame_done,
                       out_i.out_byte, out_i.last_of_run, out_i.frame_done);
          end
        end
        beat_index++;
      end

      if (in_valid_i && in_ready_i) predict_frame_bytes(in_i);

      // The register takes effect after this edge, like the block's own.
      if (cfg_we_i) append_ack_q = cfg_wdata_i;

      error_count_o <= error_count;
      pending_o     <= frame_bytes_q.size();
    end
  end

endmodule

/* tb/sv/tb_ft12_frame_builder.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// FT1.2 frame builder testbench
// Drives directed and random payload beats with random gaps and back
// pressure, changes the ack register between phases, and lets the frame
// scoreboard judge every output byte.
// ---------------------------------------------------------------------------
module tb_ft12_frame_builder;

  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned RandomItems   = 345;
  localparam int unsigned TailCycles    = 40;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic                cfg_wdata = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  ft12_pkg::ft12_in_t  in_beat   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ft12_pkg::ft12_out_t out_beat;

  int        error_count;
  int        pending_bytes;

  // Pacing controls shared between the sender and the receiver.
  bit        tx_quiet     = 1'b0;
  bit        rx_quiet     = 1'b0;
  bit        hold_off_req = 1'b0;

  // Beats of the current phase, and the sender's view of the open frame.
  ft12_pkg::ft12_in_t stim_q[$];
  int        stim_left = 0;
  bit        big_due   = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ft12_frame_builder uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_beat)
  );

  ft12_frame_checker u_frame_chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_i          (in_beat),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_i         (out_beat),
    .error_count_o (error_count),
    .pending_o     (pending_bytes)
  );

  task automatic add_beat(input logic [7:0] payload, input logic [7:0] len);
    ft12_pkg::ft12_in_t b;
    b.payload_byte = payload;
    b.frame_length = len;
    stim_q.push_back(b);
  endtask

  // Sends every queued beat, each after its own random gap.
  task automatic drive_phase();
    int gap;
    while (stim_q.size() > 0) begin
      gap = tx_quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_beat  <= stim_q.pop_front();
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending_bytes != 0) @(posedge clk);
  endtask

  task automatic set_append_ack(input logic value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly short frames; the length field of mid-frame beats is noise.
  function automatic ft12_pkg::ft12_in_t next_random_beat();
    ft12_pkg::ft12_in_t b;
    int                 r;
    int                 eff;
    b.payload_byte = 8'($urandom_range(0, 255));
    if (stim_left == 0) begin
      if (big_due) begin
        b.frame_length = 8'd255;
        big_due = 1'b0;
      end else begin
        r = $urandom_range(0, 15);
        if (r == 0) b.frame_length = 8'd0;
        else if (r < 12) b.frame_length = 8'($urandom_range(1, 5));
        else b.frame_length = 8'($urandom_range(6, 24));
      end
      eff = (b.frame_length == 8'd0) ? 1 :
            (b.frame_length > ft12_pkg::MaxPayloadDefault) ?
              ft12_pkg::MaxPayloadDefault : b.frame_length;
      stim_left = eff - 1;
    end else begin
      b.frame_length = 8'($urandom_range(0, 255));
      stim_left--;
    end
    return b;
  endfunction

  // Receiver: a random stall before each beat, plus one long hold-off.
  initial begin : receiver
    int w;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      w = rx_quiet ? 0 : $urandom_range(0, 19);
      if (hold_off_req) begin
        w += HoldOffCycles;
        hold_off_req = 1'b0;
      end
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int phase;
    int sent;
    int n;
    int k;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Ack on from reset: one-byte frames, a zero length, field extremes.
    add_beat(8'h00, 8'd1);
    add_beat(8'hFF, 8'd0);
    add_beat(8'hFF, 8'd2);
    add_beat(8'h80, 8'hAA);
    add_beat(8'h01, 8'd3);
    add_beat(8'h7F, 8'hFF);
    add_beat(8'hFE, 8'h00);
    drive_phase();

    // Ack off, with a checksum that wraps.
    set_append_ack(1'b0);
    add_beat(8'h55, 8'd1);
    add_beat(8'hFF, 8'd2);
    add_beat(8'hFF, 8'h55);
    drive_phase();

    // Ack turned back on in the middle of a frame.
    add_beat(8'h12, 8'd3);
    drive_phase();
    set_append_ack(1'b1);
    add_beat(8'h34, 8'hFF);
    add_beat(8'h56, 8'h00);
    drive_phase();

    // Random phases; register writes often land in the middle of a frame.
    sent  = 0;
    phase = 0;
    while (sent < RandomItems) begin
      set_append_ack((phase % 3 == 0) ? 1'b0 :
                     (phase % 3 == 1) ? 1'b1 : logic'($urandom_range(0, 1)));
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      n = $urandom_range(15, 45);
      if (phase == 1) begin
        // Long receiver stall against back-to-back beats fills the block.
        hold_off_req = 1'b1;
        tx_quiet     = 1'b1;
        n            = 40;
      end
      if (phase == 3) big_due = 1'b1;
      for (k = 0; k < n; k++) stim_q.push_back(next_random_beat());
      drive_phase();
      sent += n;
      phase++;
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (error_count == 0 && pending_bytes == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
